[rtl/psc_pkg.sv]
// ---------------------------------------------------------------------------
// psc_pkg
// shared widths, register codes, types and helpers of the palette scaler
// ---------------------------------------------------------------------------
package psc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int MAX_SIDE        = 512;

	localparam int PAL_AW   = $clog2(PALETTE_ENTRIES);
	localparam int IDX_W    = 8;
	localparam int CHAN_W   = 8;
	localparam int RGB_W    = 16;
	localparam int CFG_W    = 10;
	localparam int CFG_AW   = 2;
	localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
	localparam int SUM_W    = 2 * SIDE_W - 1;
	localparam int CMP_W    = (CFG_W > SIDE_W) ? CFG_W : SIDE_W;

	localparam logic [CFG_W-1:0] SRC_W_RST = CFG_W'(256);
	localparam logic [CFG_W-1:0] SRC_H_RST = CFG_W'(240);
	localparam logic [CFG_W-1:0] DST_W_RST = CFG_W'(240);
	localparam logic [CFG_W-1:0] DST_H_RST = CFG_W'(240);

	typedef enum logic [CFG_AW-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL   = 1'b0,
		OP_PAL_WR  = 1'b1
	} op_t;

	// clamped frame geometry
	typedef struct packed {
		logic [SIDE_W-1:0] sw;
		logic [SIDE_W-1:0] sh;
		logic [SIDE_W-1:0] dw;
		logic [SIDE_W-1:0] dh;
	} size_t;

	// scan decision for the current pixel
	typedef struct packed {
		logic sel;
		logic row_end;
		logic frame_end;
	} pick_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] raw,
			input logic [SIDE_W-1:0] hi);
		logic [SIDE_W-1:0] res;
		if (raw == '0) begin
			res = SIDE_W'(1);
		end else if (CMP_W'(raw) > CMP_W'(hi)) begin
			res = hi;
		end else begin
			res = SIDE_W'(raw);
		end
		return res;
	endfunction

	function automatic logic [RGB_W-1:0] to_rgb565(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

[rtl/psc_if.sv]
// ---------------------------------------------------------------------------
// psc_if
// valid/ready channels of the palette scaler: input items, results, config
// ---------------------------------------------------------------------------
interface psc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [psc_pkg::IDX_W-1:0]   color_index;
	logic [psc_pkg::CHAN_W-1:0]  red;
	logic [psc_pkg::CHAN_W-1:0]  green;
	logic [psc_pkg::CHAN_W-1:0]  blue;

	modport source (output valid, op, color_index, red, green, blue, input ready);
	modport sink (input valid, op, color_index, red, green, blue, output ready);
endinterface

interface psc_out_if;
	logic                        valid;
	logic                        ready;
	logic [psc_pkg::RGB_W-1:0]   rgb565;
	logic                        row_end;
	logic                        frame_end;

	modport source (output valid, rgb565, row_end, frame_end, input ready);
	modport sink (input valid, rgb565, row_end, frame_end, output ready);
endinterface

interface psc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [psc_pkg::CFG_AW-1:0]  index;
	logic [psc_pkg::CFG_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/palette_nearest_neighbor_scaler.sv]
// ---------------------------------------------------------------------------
// palette_nearest_neighbor_scaler
// nearest-neighbor downscaler for an indexed pixel stream with rgb565 palette
// ---------------------------------------------------------------------------
// result: a picked pixel's result is registered and shows in the cycle after it is accepted
// throughput: one item per cycle while the output is not stalled; the output register is the only stage and
//   frees itself in the same cycle its result is taken
// reset: sizes return to 256x240 source, 240x240 destination, scan at the
//   top-left pixel; palette contents are undefined until written
// ---------------------------------------------------------------------------
module palette_nearest_neighbor_scaler (
	input  logic          clk,
	input  logic          arst_n,
	psc_in_if.sink        in_item,
	psc_out_if.source     out_item,
	psc_cfg_if.sink       cfg
);

	psc_pkg::size_t size;
	psc_pkg::pick_t pick;
	logic           restart;

	logic           accept;
	logic           is_pixel;
	logic           is_pal_wr;
	logic           emit;

	// output register state
	logic           out_valid_q;
	logic           row_end_q;
	logic           frame_end_q;

	// accept whenever the output register is empty or drains this cycle
	assign in_item.ready = !out_valid_q || out_item.ready;
	assign accept        = in_item.valid && in_item.ready;
	assign is_pixel      = accept && (psc_pkg::op_t'(in_item.op) == psc_pkg::OP_PIXEL);
	assign is_pal_wr     = accept && (psc_pkg::op_t'(in_item.op) == psc_pkg::OP_PAL_WR);

	// a pixel gives a result only when both accumulators pick it
	assign emit = is_pixel && pick.sel;

	psc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.size    (size),
		.restart (restart)
	);

	// scan advances on every pixel item, palette writes leave it alone
	psc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.size    (size),
		.restart (restart),
		.advance (is_pixel),
		.pick    (pick)
	);

	// read data register doubles as the color part of the output register:
	// it only loads on a picked pixel, so it holds while a result is stalled
	psc_palette u_palette (
		.clk     (clk),
		.wr_en   (is_pal_wr),
		.rd_en   (emit),
		.idx     (in_item.color_index),
		.wr_data (psc_pkg::to_rgb565(in_item.red, in_item.green, in_item.blue)),
		.rd_data (out_item.rgb565)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// flags travel with the color
	always_ff @(posedge clk) begin
		if (emit) begin
			row_end_q   <= pick.row_end;
			frame_end_q <= pick.frame_end;
		end
	end

	assign out_item.valid     = out_valid_q;
	assign out_item.row_end   = row_end_q;
	assign out_item.frame_end = frame_end_q;

endmodule

[rtl/psc_cfg.sv]
// ---------------------------------------------------------------------------
// psc_cfg
// size registers, clamping and scan restart on every register write
// ---------------------------------------------------------------------------
module psc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	psc_cfg_if.sink           cfg,
	output psc_pkg::size_t    size,
	output logic              restart
);

	logic [psc_pkg::CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic                      wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign restart   = wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= psc_pkg::SRC_W_RST;
			src_h_q <= psc_pkg::SRC_H_RST;
			dst_w_q <= psc_pkg::DST_W_RST;
			dst_h_q <= psc_pkg::DST_H_RST;
		end else if (wr) begin
			unique case (psc_pkg::cfg_reg_t'(cfg.index))
				psc_pkg::REG_SRC_WIDTH:  src_w_q <= cfg.data;
				psc_pkg::REG_SRC_HEIGHT: src_h_q <= cfg.data;
				psc_pkg::REG_DST_WIDTH:  dst_w_q <= cfg.data;
				psc_pkg::REG_DST_HEIGHT: dst_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// destination sides are capped by the clamped source sides
	always_comb begin
		size.sw = psc_pkg::clamp_side(src_w_q, psc_pkg::SIDE_W'(psc_pkg::MAX_SIDE));
		size.sh = psc_pkg::clamp_side(src_h_q, psc_pkg::SIDE_W'(psc_pkg::MAX_SIDE));
		size.dw = psc_pkg::clamp_side(dst_w_q, size.sw);
		size.dh = psc_pkg::clamp_side(dst_h_q, size.sh);
	end

endmodule

[rtl/psc_scan.sv]
// ---------------------------------------------------------------------------
// psc_scan
// column and row accumulators that pick the nearest-neighbor source pixels
// ---------------------------------------------------------------------------
module psc_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  psc_pkg::size_t    size,
	input  logic              restart,
	input  logic              advance,
	output psc_pkg::pick_t    pick
);

	logic [psc_pkg::SIDE_W-1:0] col_q, row_q, tcol_q, trow_q;
	logic [psc_pkg::SUM_W-1:0]  col_tsum_q, col_psum_q, row_tsum_q, row_psum_q;
	logic                       row_sel_q;

	logic                       row_sel;
	logic [psc_pkg::SIDE_W-1:0] col_nxt, row_nxt, tcol_nxt, trow_nxt;
	logic                       row_wrap, frame_wrap;

	always_comb begin
		// row decision is refreshed at the first column of each source row
		if (col_q == '0) begin
			row_sel = (trow_q < size.dh) &&
				(row_tsum_q < row_psum_q + psc_pkg::SUM_W'(size.dh));
		end else begin
			row_sel = row_sel_q;
		end
		tcol_nxt       = tcol_q + 1'b1;
		trow_nxt       = trow_q + 1'b1;
		col_nxt        = col_q + 1'b1;
		row_nxt        = row_q + 1'b1;
		row_wrap       = (col_nxt >= size.sw);
		frame_wrap     = (row_nxt >= size.sh);
		pick.sel       = row_sel && (tcol_q < size.dw) &&
			(col_tsum_q < col_psum_q + psc_pkg::SUM_W'(size.dw));
		pick.row_end   = (tcol_nxt == size.dw);
		pick.frame_end = pick.row_end && (trow_nxt == size.dh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			tcol_q     <= '0;
			trow_q     <= '0;
			col_tsum_q <= '0;
			col_psum_q <= '0;
			row_tsum_q <= '0;
			row_psum_q <= '0;
			row_sel_q  <= 1'b0;
		end else if (restart) begin
			col_q      <= '0;
			row_q      <= '0;
			tcol_q     <= '0;
			trow_q     <= '0;
			col_tsum_q <= '0;
			col_psum_q <= '0;
			row_tsum_q <= '0;
			row_psum_q <= '0;
			row_sel_q  <= 1'b0;
		end else if (advance) begin
			if (!row_wrap) begin
				col_q      <= col_nxt;
				col_psum_q <= col_psum_q + psc_pkg::SUM_W'(size.dw);
				row_sel_q  <= row_sel;
				if (pick.sel) begin
					tcol_q     <= tcol_nxt;
					col_tsum_q <= col_tsum_q + psc_pkg::SUM_W'(size.sw);
				end
			end else begin
				col_q      <= '0;
				tcol_q     <= '0;
				col_tsum_q <= '0;
				col_psum_q <= '0;
				if (frame_wrap) begin
					row_q      <= '0;
					trow_q     <= '0;
					row_tsum_q <= '0;
					row_psum_q <= '0;
					row_sel_q  <= 1'b0;
				end else begin
					row_q      <= row_nxt;
					row_psum_q <= row_psum_q + psc_pkg::SUM_W'(size.dh);
					row_sel_q  <= row_sel;
					if (row_sel) begin
						trow_q     <= trow_nxt;
						row_tsum_q <= row_tsum_q + psc_pkg::SUM_W'(size.sh);
					end
				end
			end
		end
	end

endmodule

[rtl/psc_palette.sv]
// ---------------------------------------------------------------------------
// psc_palette
// rgb565 color table with one write port and a registered read port
// ---------------------------------------------------------------------------
module psc_palette (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic                        rd_en,
	input  logic [psc_pkg::IDX_W-1:0]   idx,
	input  logic [psc_pkg::RGB_W-1:0]   wr_data,
	output logic [psc_pkg::RGB_W-1:0]   rd_data
);

	logic [psc_pkg::RGB_W-1:0] mem [psc_pkg::PALETTE_ENTRIES];
	logic [psc_pkg::RGB_W-1:0] rd_s1;
	logic                      hit_s1;
	logic                      hit;

	// indexes past the table end are dropped on write and read back as black
	assign hit = ((psc_pkg::IDX_W + 1)'(idx) < (psc_pkg::IDX_W + 1)'(psc_pkg::PALETTE_ENTRIES));

	always_ff @(posedge clk) begin
		if (wr_en && hit) begin
			mem[idx[psc_pkg::PAL_AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_s1  <= mem[idx[psc_pkg::PAL_AW-1:0]];
			hit_s1 <= hit;
		end
	end

	assign rd_data = hit_s1 ? rd_s1 : '0;

endmodule
